[src/ceeh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceeh_pkg
// Shared widths, codes, and controller/datapath interface types for the chain
// end-to-end distance histogram.
// ----------------------------------------------------------------------------
package ceeh_pkg;

	localparam int BINS      = 1024;
	localparam int BIN_W     = $clog2(BINS);
	localparam int AXES      = 3;
	localparam int COORD_W   = 20;
	localparam int BOX_W     = 20;
	localparam int INV_W     = 16;
	localparam int DIFF_W    = COORD_W + 2;
	localparam int SUM_W     = 27;
	localparam int PROD_W    = 2 * SUM_W - 1;
	localparam int SQ_W      = PROD_W + 1;
	localparam int DIST_W    = 26;
	localparam int CNT_W     = 32;
	localparam int RBIN_W    = 10;
	localparam int TDATA_W   = 72;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam logic [2:0] REG_BOX_X   = 3'd0;
	localparam logic [2:0] REG_BOX_Y   = 3'd1;
	localparam logic [2:0] REG_BOX_Z   = 3'd2;
	localparam logic [2:0] REG_INV_BIN = 3'd3;
	localparam logic [2:0] REG_STAT_EN = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [AXES-1:0][BOX_W-1:0] box;
		logic [INV_W-1:0]           inv_bin_width;
		logic                       stat_enable;
	} cfg_t;

	typedef struct packed {
		logic       in_load;
		logic       wrap_en;
		logic       acc_en;
		logic       sq_en;
		logic [1:0] sq_axis;
		logic       psum_ld;
		logic       psum_add;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       dist_en;
		logic       bin_en;
		logic       rd_req;
		logic       rd_bin;
		logic       out_read;
		logic       out_chain;
		logic       clr_en;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic sqrt_done;
		logic out_free;
		logic last_s2;
	} status_t;

endpackage

[src/chain_end_to_end_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_end_to_end_histogram
// End-to-end distance of polymer chains in a periodic box, with histogram.
// ----------------------------------------------------------------------------
// Input stream: one request per beat. tuser 0 = bead (Q12.8 position, first
// flag in tdata, last flag on tlast); tuser 1 = read of one histogram bin.
// Output stream: tuser 0 = chain result (distance, bin, in-range, count),
// tuser 1 = bin read result. Beads that are not last give no output.
// Box lengths, bin scale and the statistics enable sit on the APB port.
// A bead passes a wrap stage, then an accumulate stage; the next request can
// be taken in the accumulate stage unless the bead is last. A last bead's
// result follows squaring on one shared multiplier, the bit-pair square root
// loop, then scaling, a histogram RAM read and the update/write.
// A bin read addresses the histogram RAM, then loads the output register.
// After reset the histogram RAM is cleared one bin per cycle, all 1024 bins,
// with s_axis_tready low; APB writes are taken throughout.
// A result waits in the output register while m_axis_tready is low; beads
// that produce no output keep flowing, the rest wait for the register.
// ----------------------------------------------------------------------------
module chain_end_to_end_histogram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// pos_x[19:0], pos_y[39:20], pos_z[59:40], first_bead[60], read_bin[70:61]
	input  logic [ceeh_pkg::TDATA_W-1:0] s_axis_tdata,
	// req_type
	input  logic                         s_axis_tuser,
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// distance[25:0], bin_index[35:26], bin_in_range[36], bin_count[68:37]
	output logic [ceeh_pkg::TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic                         m_axis_tuser,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ceeh_pkg::APB_AW-1:0]  paddr,
	input  logic [ceeh_pkg::APB_DW-1:0]  pwdata,
	output logic [ceeh_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	ceeh_pkg::cfg_t    cfg;
	ceeh_pkg::cmd_t    cmd;
	ceeh_pkg::status_t st;

	ceeh_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	ceeh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_req_type(s_axis_tuser),
		.s_ready   (s_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	ceeh_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.st      (st),
		.cfg     (cfg),
		.s_tdata (s_axis_tdata),
		.s_tlast (s_axis_tlast),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata),
		.m_tuser (m_axis_tuser)
	);

endmodule

[src/ceeh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceeh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ceeh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/ceeh_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceeh_cfg
// APB register file: box lengths, bin scale and statistics enable.
// ----------------------------------------------------------------------------
module ceeh_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ceeh_pkg::APB_AW-1:0] paddr,
	input  logic [ceeh_pkg::APB_DW-1:0] pwdata,
	output logic [ceeh_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output ceeh_pkg::cfg_t              cfg
);

	ceeh_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[ceeh_pkg::APB_AW-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box[0]         <= ceeh_pkg::BOX_W'(25600);
			cfg_q.box[1]         <= ceeh_pkg::BOX_W'(25600);
			cfg_q.box[2]         <= ceeh_pkg::BOX_W'(25600);
			cfg_q.inv_bin_width  <= ceeh_pkg::INV_W'(2560);
			cfg_q.stat_enable    <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				ceeh_pkg::REG_BOX_X:   cfg_q.box[0] <= pwdata[ceeh_pkg::BOX_W-1:0];
				ceeh_pkg::REG_BOX_Y:   cfg_q.box[1] <= pwdata[ceeh_pkg::BOX_W-1:0];
				ceeh_pkg::REG_BOX_Z:   cfg_q.box[2] <= pwdata[ceeh_pkg::BOX_W-1:0];
				ceeh_pkg::REG_INV_BIN: cfg_q.inv_bin_width <= pwdata[ceeh_pkg::INV_W-1:0];
				ceeh_pkg::REG_STAT_EN: cfg_q.stat_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ceeh_pkg::REG_BOX_X:   prdata = ceeh_pkg::APB_DW'(cfg_q.box[0]);
			ceeh_pkg::REG_BOX_Y:   prdata = ceeh_pkg::APB_DW'(cfg_q.box[1]);
			ceeh_pkg::REG_BOX_Z:   prdata = ceeh_pkg::APB_DW'(cfg_q.box[2]);
			ceeh_pkg::REG_INV_BIN: prdata = ceeh_pkg::APB_DW'(cfg_q.inv_bin_width);
			ceeh_pkg::REG_STAT_EN: prdata = ceeh_pkg::APB_DW'(cfg_q.stat_enable);
			default:               prdata = '0;
		endcase
	end

endmodule

[src/ceeh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceeh_ctrl
// Sequencer: histogram clear, bead wrap/accumulate, square root, bin update,
// and bin read requests.
// ----------------------------------------------------------------------------
module ceeh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	input  logic              s_req_type,
	output logic              s_ready,
	input  ceeh_pkg::status_t st,
	output ceeh_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		WRAP,
		ACC,
		RD_ADDR,
		RD_DATA,
		SQX,
		SQY,
		SQZ,
		SQ_INIT,
		SQRT,
		DIST,
		BIN,
		HRD,
		HUPD
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		s_ready   = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			CLEAR: begin
				cmd.clr_en = 1'b1;
				if (st.clr_done) begin
					state_nxt = IDLE;
				end
			end
			IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.in_load = 1'b1;
					state_nxt   = s_req_type ? RD_ADDR : WRAP;
				end
			end
			WRAP: begin
				cmd.wrap_en = 1'b1;
				state_nxt   = ACC;
			end
			ACC: begin
				cmd.acc_en = 1'b1;
				if (st.last_s2) begin
					state_nxt = SQX;
				end else begin
					s_ready = 1'b1;
					if (s_valid) begin
						cmd.in_load = 1'b1;
						state_nxt   = s_req_type ? RD_ADDR : WRAP;
					end else begin
						state_nxt = IDLE;
					end
				end
			end
			RD_ADDR: begin
				cmd.rd_req = 1'b1;
				state_nxt  = RD_DATA;
			end
			RD_DATA: begin
				if (st.out_free) begin
					cmd.out_read = 1'b1;
					state_nxt    = IDLE;
				end
			end
			SQX: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = ceeh_pkg::AXIS_X;
				state_nxt   = SQY;
			end
			SQY: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = ceeh_pkg::AXIS_Y;
				cmd.psum_ld = 1'b1;
				state_nxt   = SQZ;
			end
			SQZ: begin
				cmd.sq_en    = 1'b1;
				cmd.sq_axis  = ceeh_pkg::AXIS_Z;
				cmd.psum_add = 1'b1;
				state_nxt    = SQ_INIT;
			end
			SQ_INIT: begin
				cmd.sqrt_init = 1'b1;
				state_nxt     = SQRT;
			end
			SQRT: begin
				if (st.sqrt_done) begin
					state_nxt = DIST;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			DIST: begin
				cmd.dist_en = 1'b1;
				state_nxt   = BIN;
			end
			BIN: begin
				cmd.bin_en = 1'b1;
				state_nxt  = HRD;
			end
			HRD: begin
				cmd.rd_bin = 1'b1;
				state_nxt  = HUPD;
			end
			HUPD: begin
				if (st.out_free) begin
					cmd.out_chain = 1'b1;
					state_nxt     = IDLE;
				end
			end
			default: state_nxt = IDLE;
		endcase
	end

endmodule

[src/ceeh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceeh_dp
// Datapath: bond wrap and saturating sums per axis, shared squarer, iterative
// square root, bin scaling, histogram RAM and the output register.
// ----------------------------------------------------------------------------
module ceeh_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ceeh_pkg::cmd_t               cmd,
	output ceeh_pkg::status_t            st,
	input  ceeh_pkg::cfg_t               cfg,
	input  logic [ceeh_pkg::TDATA_W-1:0] s_tdata,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ceeh_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tuser
);

	localparam int DW   = ceeh_pkg::DIFF_W;
	localparam int SW   = ceeh_pkg::SUM_W;
	localparam int BW   = ceeh_pkg::BIN_W;
	localparam int CW   = ceeh_pkg::CNT_W;
	localparam int QW   = ceeh_pkg::SQ_W;
	localparam int PW   = ceeh_pkg::PROD_W;
	localparam int XW   = ceeh_pkg::DIST_W;
	localparam int MW   = ceeh_pkg::DIST_W + ceeh_pkg::INV_W;
	localparam int CRDW = ceeh_pkg::COORD_W;

	// input stage
	logic [ceeh_pkg::AXES-1:0][CRDW-1:0] pos_s1;
	logic                                first_s1;
	logic                                last_s1;
	logic [ceeh_pkg::RBIN_W-1:0]         rbin_s1;

	// bond stage
	logic [ceeh_pkg::AXES-1:0][CRDW-1:0] prev_q;
	logic signed [DW-1:0]                d1_s2   [ceeh_pkg::AXES];
	logic signed [DW-1:0]                d1_nxt  [ceeh_pkg::AXES];
	logic                                first_s2;
	logic                                last_s2;
	logic signed [SW-1:0]                sum_q   [ceeh_pkg::AXES];
	logic signed [SW-1:0]                sum_nxt [ceeh_pkg::AXES];

	// chain end
	logic signed [SW-1:0]    sq_sel;
	logic signed [2*SW-1:0]  sq_full;
	logic [PW-1:0]           prod_q;
	logic [QW-1:0]           psum_q;
	logic [QW-1:0]           v_q;
	logic [QW-1:0]           res_q;
	logic [QW-1:0]           bit_q;
	logic [QW-1:0]           rt_try;
	logic [XW-1:0]           dist_q;
	logic [MW-1:0]           bin_prod;
	logic [XW-1:0]           bin_full_q;
	logic                    bin_ok;

	// histogram
	logic [BW-1:0]           clr_q;
	logic                    ram_we;
	logic [BW-1:0]           ram_waddr;
	logic [CW-1:0]           ram_wdata;
	logic                    ram_re;
	logic [BW-1:0]           ram_raddr;
	logic [CW-1:0]           ram_rdata;
	logic                    cnt_inc;
	logic [CW-1:0]           cnt_new;
	logic                    rd_ok;

	// output register
	logic                        out_valid_q;
	logic                        out_kind_q;
	logic [XW-1:0]               out_dist_q;
	logic [ceeh_pkg::RBIN_W-1:0] out_bin_q;
	logic                        out_ok_q;
	logic [CW-1:0]               out_cnt_q;

	// minimum-image wrap, high side then low side, then saturating sum
	always_comb begin
		logic signed [DW-1:0]   diff;
		logic signed [DW-1:0]   len;
		logic signed [DW:0]     dbl;
		logic signed [DW:0]     nlen;
		logic signed [DW-1:0]   d2;
		logic signed [SW:0]     acc;
		for (int i = 0; i < ceeh_pkg::AXES; i++) begin
			len  = $signed({2'b00, cfg.box[i]});
			diff = $signed({2'b00, pos_s1[i]}) - $signed({2'b00, prev_q[i]});
			dbl  = {diff, 1'b0};
			d1_nxt[i] = (dbl > $signed({len[DW-1], len})) ? diff - len : diff;

			dbl  = {d1_s2[i], 1'b0};
			nlen = -{len[DW-1], len};
			d2   = (dbl < nlen) ? d1_s2[i] + len : d1_s2[i];
			acc  = {sum_q[i][SW-1], sum_q[i]} + {{(SW + 1 - DW){d2[DW-1]}}, d2};
			if (acc > $signed({2'b00, {(SW - 1){1'b1}}})) begin
				sum_nxt[i] = $signed({1'b0, {(SW - 1){1'b1}}});
			end else if (acc < $signed({2'b11, {(SW - 1){1'b0}}})) begin
				sum_nxt[i] = $signed({1'b1, {(SW - 1){1'b0}}});
			end else begin
				sum_nxt[i] = acc[SW-1:0];
			end
		end
	end

	always_comb begin
		case (cmd.sq_axis)
			ceeh_pkg::AXIS_Y: sq_sel = sum_q[1];
			ceeh_pkg::AXIS_Z: sq_sel = sum_q[2];
			default:          sq_sel = sum_q[0];
		endcase
		sq_full = sq_sel * sq_sel;
	end

	assign rt_try   = res_q + bit_q;
	assign bin_prod = dist_q * cfg.inv_bin_width;
	assign bin_ok   = 32'(bin_full_q) < 32'(ceeh_pkg::BINS);
	assign rd_ok    = 32'(rbin_s1) < 32'(ceeh_pkg::BINS);
	assign cnt_inc  = cfg.stat_enable & bin_ok & ~(&ram_rdata);
	assign cnt_new  = cnt_inc ? ram_rdata + CW'(1) : ram_rdata;

	assign ram_we    = cmd.clr_en | (cmd.out_chain & cnt_inc);
	assign ram_waddr = cmd.clr_en ? clr_q : bin_full_q[BW-1:0];
	assign ram_wdata = cmd.clr_en ? '0 : cnt_new;
	assign ram_re    = cmd.rd_req | cmd.rd_bin;
	assign ram_raddr = cmd.rd_bin ? bin_full_q[BW-1:0] : BW'(rbin_s1);

	ceeh_ram #(
		.WIDTH(CW),
		.DEPTH(ceeh_pkg::BINS)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			for (int i = 0; i < ceeh_pkg::AXES; i++) begin
				sum_q[i] <= '0;
			end
			last_s2     <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wrap_en) begin
				prev_q  <= pos_s1;
				last_s2 <= last_s1;
			end
			for (int i = 0; i < ceeh_pkg::AXES; i++) begin
				if (cmd.sqrt_init || (cmd.acc_en && first_s2)) begin
					sum_q[i] <= '0;
				end else if (cmd.acc_en) begin
					sum_q[i] <= sum_nxt[i];
				end
			end
			if (cmd.clr_en) begin
				clr_q <= clr_q + BW'(1);
			end
			if (cmd.out_read || cmd.out_chain) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			pos_s1[0] <= s_tdata[CRDW-1:0];
			pos_s1[1] <= s_tdata[2*CRDW-1:CRDW];
			pos_s1[2] <= s_tdata[3*CRDW-1:2*CRDW];
			first_s1  <= s_tdata[3*CRDW];
			rbin_s1   <= s_tdata[3*CRDW+ceeh_pkg::RBIN_W:3*CRDW+1];
			last_s1   <= s_tlast;
		end
		if (cmd.wrap_en) begin
			first_s2 <= first_s1;
			for (int i = 0; i < ceeh_pkg::AXES; i++) begin
				d1_s2[i] <= d1_nxt[i];
			end
		end
		if (cmd.sq_en) begin
			prod_q <= sq_full[PW-1:0];
		end
		if (cmd.psum_ld) begin
			psum_q <= QW'(prod_q);
		end else if (cmd.psum_add) begin
			psum_q <= psum_q + QW'(prod_q);
		end
		if (cmd.sqrt_init) begin
			v_q   <= psum_q + QW'(prod_q);
			res_q <= '0;
			bit_q <= QW'(1) << (2 * (SW - 1));
		end else if (cmd.sqrt_step) begin
			if (v_q >= rt_try) begin
				v_q   <= v_q - rt_try;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.dist_en) begin
			dist_q <= (res_q > QW'({XW{1'b1}})) ? {XW{1'b1}} : res_q[XW-1:0];
		end
		if (cmd.bin_en) begin
			bin_full_q <= bin_prod[MW-1:ceeh_pkg::INV_W];
		end
		if (cmd.out_read) begin
			out_kind_q <= 1'b1;
			out_dist_q <= '0;
			out_bin_q  <= rbin_s1;
			out_ok_q   <= rd_ok;
			out_cnt_q  <= rd_ok ? ram_rdata : '0;
		end else if (cmd.out_chain) begin
			out_kind_q <= 1'b0;
			out_dist_q <= dist_q;
			out_bin_q  <= bin_ok ? ceeh_pkg::RBIN_W'(bin_full_q)
			                     : ceeh_pkg::RBIN_W'(ceeh_pkg::BINS - 1);
			out_ok_q   <= bin_ok;
			out_cnt_q  <= bin_ok ? cnt_new : '0;
		end
	end

	assign st.clr_done  = (clr_q == BW'(ceeh_pkg::BINS - 1));
	assign st.sqrt_done = (bit_q == '0);
	assign st.out_free  = ~out_valid_q | m_tready;
	assign st.last_s2   = last_s2;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = ceeh_pkg::TDATA_W'({out_cnt_q, out_ok_q, out_bin_q, out_dist_q});

endmodule

[tb/tb_chain_end_to_end_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chain_end_to_end_histogram
// Self-checking bench for the chain end-to-end distance histogram.
// ----------------------------------------------------------------------------
// Bead and bin-read requests go in on the slave stream. Every accepted request
// is run through a bench-side model of the wrap, sums, root, binning and
// histogram. Its expected result is queued and compared field by field with
// the master stream. Directed cases cover the flag combinations, wrap edges,
// register extremes, sum and distance saturation, back-pressure and a pause
// mid-chain. Four random phases with different sender and receiver idle rates
// follow.
// ----------------------------------------------------------------------------
module tb_chain_end_to_end_histogram;
	import ceeh_pkg::*;

	localparam logic REQ_BEAD   = 1'b0;
	localparam logic REQ_READ   = 1'b1;
	localparam logic KIND_CHAIN = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam longint SUM_HI = 64'sd67108863;
	localparam longint SUM_LO = -64'sd67108864;
	localparam longint unsigned DIST_HI = 64'd67108863;
	localparam bit [19:0] COORD_MAX = 20'hFFFFF;
	localparam bit [19:0] STRIDE    = 20'd524287;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 48;

	typedef struct packed {
		bit             rd;
		bit [9:0]       rbin;
		bit             first;
		bit             last;
		bit [2:0][19:0] pos;
	} bead_req_t;

	typedef struct packed {
		logic        kind;
		logic [25:0] distance;
		logic [9:0]  bin;
		logic        in_range;
		logic [31:0] count;
	} chain_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic                m_axis_tuser;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// bench-side copy of block state and registers
	bit [19:0]  box_len [3] = '{20'd25600, 20'd25600, 20'd25600};
	bit [15:0]  inv_width = 16'd2560;
	bit         stat_on = 1'b0;
	bit [19:0]  prev_pos [3];
	longint     bond_sum [3];
	bit [31:0]  hist_count [BINS];

	chain_result_t results_due [$];
	int fails = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_tgl = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	chain_end_to_end_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 27; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	// returns 1 when the request produces a result
	function automatic bit predict_request(input bead_req_t r, output chain_result_t res);
		longint d, l;
		longint unsigned mag, sq_sum, root_val, bin;
		res = '0;
		if (r.rd == REQ_READ) begin
			res.kind = KIND_READ;
			res.bin = r.rbin;
			res.in_range = 1'b1;
			res.count = hist_count[r.rbin];
			return 1'b1;
		end
		for (int a = 0; a < 3; a++) begin
			if (r.first) begin
				bond_sum[a] = 0;
			end else begin
				d = r.pos[a];
				d = d - prev_pos[a];
				l = box_len[a];
				if (2 * d > l) d = d - l;
				if (2 * d < -l) d = d + l;
				d = bond_sum[a] + d;
				bond_sum[a] = (d > SUM_HI) ? SUM_HI : ((d < SUM_LO) ? SUM_LO : d);
			end
			prev_pos[a] = r.pos[a];
		end
		if (!r.last) return 1'b0;
		sq_sum = 0;
		for (int a = 0; a < 3; a++) begin
			mag = (bond_sum[a] < 0) ? -bond_sum[a] : bond_sum[a];
			sq_sum = sq_sum + mag * mag;
			bond_sum[a] = 0;
		end
		root_val = root_floor(sq_sum);
		if (root_val > DIST_HI) root_val = DIST_HI;
		bin = (root_val * inv_width) >> 16;
		res.kind = KIND_CHAIN;
		res.distance = root_val[25:0];
		if (bin < BINS) begin
			res.in_range = 1'b1;
			res.bin = bin[9:0];
			if (stat_on && hist_count[bin] != 32'hFFFFFFFF)
				hist_count[bin] = hist_count[bin] + 32'd1;
			res.count = hist_count[bin];
		end else begin
			res.bin = 10'(BINS - 1);
		end
		return 1'b1;
	endfunction

	function automatic void queue_result(input chain_result_t r);
		results_due.insert(results_due.size(), r);
	endfunction

	function automatic void match_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : track_streams
		chain_result_t got, want, nxt;
		bead_req_t req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.distance = m_axis_tdata[25:0];
				got.bin = m_axis_tdata[35:26];
				got.in_range = m_axis_tdata[36];
				got.count = m_axis_tdata[68:37];
				if (results_due.size() == 0) begin
					$error("result with none pending: kind %0d distance %0d",
						got.kind, got.distance);
					fails++;
				end else begin
					want = results_due.pop_front();
					match_field("result_kind", want.kind, got.kind);
					match_field("distance", want.distance, got.distance);
					match_field("bin_index", want.bin, got.bin);
					match_field("bin_in_range", want.in_range, got.in_range);
					match_field("bin_count", want.count, got.count);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.rd = s_axis_tuser;
				req.last = s_axis_tlast;
				req.rbin = s_axis_tdata[70:61];
				req.first = s_axis_tdata[60];
				req.pos = s_axis_tdata[59:0];
				if (predict_request(req, nxt)) queue_result(nxt);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when the test toggles hold_tgl
	always @(posedge clk) begin
		if (hold_tgl != hold_seen) begin
			hold_seen <= hold_tgl;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_request(input bead_req_t r);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.rd;
		s_axis_tlast <= r.last;
		s_axis_tdata <= {1'b0, r.rbin, r.first, r.pos};
		do @(posedge clk); while (!s_axis_tready);
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, wait for every pending result, then let the pipe drain
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_BOX_X:   box_len[0] = val[19:0];
			REG_BOX_Y:   box_len[1] = val[19:0];
			REG_BOX_Z:   box_len[2] = val[19:0];
			REG_INV_BIN: inv_width = val[15:0];
			REG_STAT_EN: stat_on = val[0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input bit [19:0] bx, input bit [19:0] by,
			input bit [19:0] bz, input bit [15:0] inv, input bit stat);
		apb_write(REG_BOX_X, 32'(bx));
		apb_write(REG_BOX_Y, 32'(by));
		apb_write(REG_BOX_Z, 32'(bz));
		apb_write(REG_INV_BIN, 32'(inv));
		apb_write(REG_STAT_EN, 32'(stat));
	endtask

	function automatic bead_req_t bead_req(input bit [19:0] x, input bit [19:0] y,
			input bit [19:0] z, input bit first, input bit last);
		bead_req_t r;
		r.rd = REQ_BEAD;
		r.rbin = 10'($urandom);
		r.first = first;
		r.last = last;
		r.pos = {z, y, x};
		return r;
	endfunction

	function automatic bead_req_t read_req(input bit [9:0] rbin);
		bead_req_t r;
		r = bead_req(20'($urandom), 20'($urandom), 20'($urandom),
			1'($urandom), 1'($urandom));
		r.rd = REQ_READ;
		r.rbin = rbin;
		return r;
	endfunction

	function automatic bit [19:0] nudge(input bit [19:0] p, input int step);
		int v;
		v = int'(p) + int'($urandom_range(2 * step)) - step;
		if (v < 0) v = 0;
		if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
		return 20'(v);
	endfunction

	// well-formed chain: random walk, or random jumps that exercise the wrap
	task automatic send_chain(input int beads, input int step, input bit jumpy);
		bead_req_t r;
		r = bead_req(20'($urandom), 20'($urandom), 20'($urandom), 1'b1, beads == 1);
		for (int i = 0; i < beads; i++) begin
			if (i > 0) begin
				for (int a = 0; a < 3; a++)
					r.pos[a] = jumpy ? 20'($urandom) : nudge(r.pos[a], step);
				r.first = 1'b0;
				r.last = (i == beads - 1);
				r.rbin = 10'($urandom);
			end
			send_request(r);
		end
	endtask

	// bonds of just under half the box each way, so every axis sum saturates
	task automatic send_stride_chain(input int beads, input bit downward);
		int p;
		p = 0;
		for (int i = 0; i < beads; i++) begin
			send_request(bead_req(20'(p), 20'(p), 20'(p), i == 0, i == beads - 1));
			if (downward) begin
				p = p - int'(STRIDE);
				if (p < 0) p = p + int'(COORD_MAX);
			end else begin
				p = p + int'(STRIDE);
				if (p > int'(COORD_MAX)) p = p - int'(COORD_MAX);
			end
		end
	endtask

	task automatic test_after_reset();
		send_request(read_req(10'd0));
		send_request(read_req(10'h3FF));
		send_request(read_req(10'h155));
		// no first flag: bond taken from the reset position
		send_request(bead_req(20'd300, 20'd0, 20'd0, 1'b0, 1'b0));
		send_request(bead_req(20'd600, 20'd0, 20'd0, 1'b0, 1'b1));
		settle_block();
	endtask

	task automatic test_lone_bead();
		send_request(bead_req(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1));
		send_request(bead_req(20'd0, 20'd0, 20'd0, 1'b1, 1'b1));
		settle_block();
	endtask

	task automatic test_min_image();
		// x wraps down, y wraps up, z sits exactly on half the box
		send_request(bead_req(20'd1000, 20'd20000, 20'd0, 1'b1, 1'b0));
		send_request(bead_req(20'd20000, 20'd1000, 20'd12800, 1'b0, 1'b1));
		send_request(bead_req(20'd5000, 20'd5000, 20'd12800, 1'b1, 1'b0));
		send_request(bead_req(20'd17800, 20'd5000, 20'd0, 1'b0, 1'b1));
		// continuation after a finished chain, then a full-range bond
		send_request(bead_req(20'd0, 20'd0, 20'd0, 1'b0, 1'b0));
		send_request(bead_req(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1));
		settle_block();
	endtask

	task automatic test_config_extremes();
		load_settings(20'd1, 20'd1, 20'd1, 16'hFFFF, 1'b1);
		send_chain(4, 3000, 1'b0);
		send_chain(3, 0, 1'b1);
		settle_block();
		load_settings(COORD_MAX, COORD_MAX, COORD_MAX, 16'd1, 1'b0);
		send_chain(4, 3000, 1'b0);
		send_chain(3, 0, 1'b1);
		settle_block();
		load_settings(20'd25600, 20'd25600, 20'd25600, 16'd2560, 1'b0);
	endtask

	task automatic test_statistics();
		apb_write(REG_STAT_EN, 32'd1);
		repeat (6) send_request(bead_req(20'($urandom), 20'($urandom), 20'($urandom),
			1'b1, 1'b1));
		send_request(read_req(10'd0));
		repeat (4) send_chain(5, 500, 1'b0);
		settle_block();
		apb_write(REG_STAT_EN, 32'd0);
		repeat (2) send_request(bead_req(20'($urandom), 20'($urandom), 20'($urandom),
			1'b1, 1'b1));
		send_request(read_req(10'd0));
		settle_block();
	endtask

	task automatic test_saturation();
		load_settings(COORD_MAX, COORD_MAX, COORD_MAX, 16'd1, 1'b1);
		send_stride_chain(140, 1'b0);
		send_stride_chain(140, 1'b1);
		send_request(read_req(10'h3FF));
		settle_block();
		load_settings(20'd25600, 20'd25600, 20'd25600, 16'd2560, 1'b0);
	endtask

	task automatic test_pause_mid_chain();
		send_request(bead_req(20'd4000, 20'd4000, 20'd4000, 1'b1, 1'b0));
		send_request(bead_req(20'd4500, 20'd3500, 20'd4100, 1'b0, 1'b0));
		send_request(read_req(10'd23));
		settle_block();
		send_request(bead_req(20'd5200, 20'd3000, 20'd4300, 1'b0, 1'b0));
		send_request(bead_req(20'd5900, 20'd2600, 20'd4000, 1'b0, 1'b1));
		settle_block();
	endtask

	task automatic test_backpressure();
		hold_tgl <= ~hold_tgl;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 3) send_request(read_req(10'($urandom_range(63))));
			else send_chain($urandom_range(1, 2), 800, 1'b0);
		end
		settle_block();
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int items);
		bit [19:0] bx [3];
		bead_req_t r;
		int sent, pick, len;
		tx_idle_pct <= tx_pct;
		rx_stall_pct <= rx_pct;
		for (int a = 0; a < 3; a++) begin
			case ($urandom_range(2))
				0: bx[a] = 20'd25600;
				1: bx[a] = 20'($urandom_range(1, 4096));
				default: bx[a] = 20'($urandom_range(1, COORD_MAX));
			endcase
		end
		load_settings(bx[0], bx[1], bx[2],
			$urandom_range(1) ? 16'd2560 : 16'($urandom_range(1, 16'hFFFF)),
			1'($urandom_range(1)));
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				len = $urandom_range(1, 12);
				send_chain(len, $urandom_range(1, 2000), $urandom_range(4) == 0);
				sent += len;
			end else if (pick < 88) begin
				send_request(read_req(10'($urandom_range(1) ? $urandom_range(63)
					: $urandom)));
				sent++;
			end else begin
				// loose bead with arbitrary flags
				r = bead_req(20'($urandom), 20'($urandom), 20'($urandom),
					1'($urandom), 1'($urandom));
				send_request(r);
				sent++;
			end
		end
		settle_block();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_after_reset();
		test_lone_bead();
		test_min_image();
		test_config_extremes();
		test_statistics();
		test_saturation();
		test_pause_mid_chain();
		test_backpressure();
		test_random_phase(0, 0, 50);
		test_random_phase(65, 0, 50);
		test_random_phase(0, 65, 50);
		test_random_phase(33, 33, 50);
		tx_idle_pct <= 0;
		rx_stall_pct <= 0;
		settle_block();
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
src/ceeh_pkg.sv
src/ceeh_ram.sv
src/ceeh_cfg.sv
src/ceeh_ctrl.sv
src/ceeh_dp.sv
src/chain_end_to_end_histogram.sv
tb/tb_chain_end_to_end_histogram.sv
